// ===== rtl/core/hpt_pkg.sv =====
// ----------------------------------------------------------------------------
// hpt_pkg: shared types and constants of the point transform
// Item structs, register map and width helpers.
// ----------------------------------------------------------------------------
package hpt_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int NUM_REGS        = 8;
  localparam int REG_W           = 64;
  localparam int ADDR_W          = 6;

  // register reset values give the identity matrix at Q16.16
  localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               w_zero;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic vld;
    logic wz;
  } lane_ctrl_t;

  // width of an exact row sum: products and shifted offset plus two carry bits
  function automatic int sum_w(input int cw, input int fb);
    return ((2 * cw > cw + fb) ? 2 * cw : cw + fb) + 2;
  endfunction

endpackage

// ===== rtl/core/hpt_cfg.sv =====
// ----------------------------------------------------------------------------
// hpt_cfg: matrix coefficient registers
// APB-style write/read port onto eight 64-bit registers.
// ----------------------------------------------------------------------------
module hpt_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [hpt_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [hpt_pkg::REG_W-1:0]   cfg_pwdata,
  output logic [hpt_pkg::REG_W-1:0]   cfg_prdata,
  output logic                        cfg_pready,
  output logic [hpt_pkg::REG_W-1:0]   regs_o [hpt_pkg::NUM_REGS]
);

  logic [hpt_pkg::REG_W-1:0] regs_r [hpt_pkg::NUM_REGS];
  logic [2:0]                idx;
  logic                      wr_en;

  assign idx        = cfg_paddr[5:3];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = regs_r[idx];
  assign regs_o     = regs_r;

  // write on the access phase of a transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= hpt_pkg::REG_RESET;
    end else if (wr_en) begin
      regs_r[idx] <= cfg_pwdata;
    end
  end

endmodule

// ===== rtl/core/hpt_mac.sv =====
// ----------------------------------------------------------------------------
// hpt_mac: matrix-vector product
// Twelve multipliers, then a two-level adder tree, one level a stage.
// ----------------------------------------------------------------------------
module hpt_mac #(
  parameter int COORD_WIDTH = hpt_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = hpt_pkg::FRAC_BITS_DEF,
  localparam int SW         = hpt_pkg::sum_w(COORD_WIDTH, FRAC_BITS)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      vld_i,
  input  hpt_pkg::in_item_t         pt_i,
  input  logic [hpt_pkg::REG_W-1:0] regs_i [hpt_pkg::NUM_REGS],
  output logic                      vld_o,
  output logic signed [SW-1:0]      sum_o [4]
);

  localparam int CW = COORD_WIDTH;
  localparam int PW = 2 * CW;

  logic signed [CW-1:0] crd [3];
  logic signed [PW-1:0] prod_r [4][3];
  logic signed [SW-1:0] ofs_r  [4];
  logic signed [SW-1:0] pa_r   [4];
  logic signed [SW-1:0] pb_r   [4];
  logic signed [SW-1:0] sum_r  [4];
  logic [2:0]           vld_r;

  assign crd[0] = signed'(pt_i.in_x[CW-1:0]);
  assign crd[1] = signed'(pt_i.in_y[CW-1:0]);
  assign crd[2] = signed'(pt_i.in_z[CW-1:0]);

  for (genvar r = 0; r < 4; r++) begin : g_row
    logic signed [CW-1:0] cf [4];
    for (genvar c = 0; c < 4; c++) begin : g_cf
      assign cf[c] = signed'(regs_i[r * 2 + c / 2][(c % 2) * 32 +: CW]);
    end

    // multiply stage
    always_ff @(posedge clk) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[r][c] <= cf[c] * crd[c];
      end
      ofs_r[r] <= SW'(cf[3]) <<< FRAC_BITS;
    end

    // pair sums, then the row sum
    always_ff @(posedge clk) begin
      pa_r[r]  <= SW'(prod_r[r][0]) + SW'(prod_r[r][1]);
      pb_r[r]  <= SW'(prod_r[r][2]) + ofs_r[r];
      sum_r[r] <= pa_r[r] + pb_r[r];
    end
  end

  // advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], vld_i};
    end
  end

  assign vld_o = vld_r[2];
  assign sum_o = sum_r;

endmodule

// ===== rtl/core/hpt_div.sv =====
// ----------------------------------------------------------------------------
// hpt_div: pipelined divide and saturate lane
// Magnitudes, overflow check, one restoring quotient bit a stage, then sign.
// ----------------------------------------------------------------------------
module hpt_div #(
  parameter int COORD_WIDTH = hpt_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = hpt_pkg::FRAC_BITS_DEF,
  localparam int SW         = hpt_pkg::sum_w(COORD_WIDTH, FRAC_BITS)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   vld_i,
  input  logic signed [SW-1:0]   num_i,
  input  logic signed [SW-1:0]   den_i,
  output hpt_pkg::lane_ctrl_t    ctrl_o,
  output logic [COORD_WIDTH-1:0] res_o,
  output logic                   sat_o
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = SW + FRAC_BITS + CW;
  localparam logic [CW-1:0] POS_MAX = {1'b0, {(CW - 1){1'b1}}};
  localparam logic [CW-1:0] NEG_MAX = {1'b1, {(CW - 1){1'b0}}};

  // magnitude stage
  logic [SW-1:0] nm_r, dm_a_r;
  logic          nneg_a_r, dneg_a_r, wz_a_r, vld_a_r;

  always_ff @(posedge clk) begin
    nm_r     <= num_i[SW-1] ? SW'(-num_i) : SW'(num_i);
    dm_a_r   <= den_i[SW-1] ? SW'(-den_i) : SW'(den_i);
    nneg_a_r <= num_i[SW-1];
    dneg_a_r <= den_i[SW-1];
    wz_a_r   <= (den_i == '0);
  end

  // pipeline of quotient steps; index 0 is the overflow stage output
  logic [DW-1:0] rem_r [CW+1];
  logic [CW-1:0] q_r   [CW+1];
  logic [SW-1:0] dm_r  [CW+1];
  logic          neg_r [CW+1];
  logic          ovf_r [CW+1];
  logic          wz_r  [CW+1];
  logic          vld_r [CW+1];
  logic [DW-1:0] num_sh;

  assign num_sh = DW'(nm_r) << FRAC_BITS;

  // flag a quotient of more than CW magnitude bits
  always_ff @(posedge clk) begin
    rem_r[0] <= num_sh;
    q_r[0]   <= '0;
    dm_r[0]  <= dm_a_r;
    neg_r[0] <= nneg_a_r ^ dneg_a_r;
    ovf_r[0] <= !wz_a_r && (num_sh >= (DW'(dm_a_r) << CW));
    wz_r[0]  <= wz_a_r;
  end

  for (genvar k = 0; k < CW; k++) begin : g_step
    localparam int BIT = CW - 1 - k;
    logic [DW-1:0] dsh;
    logic          ge;

    assign dsh = DW'(dm_r[k]) << BIT;
    assign ge  = (rem_r[k] >= dsh);

    // subtract when the shifted divisor fits
    always_ff @(posedge clk) begin
      rem_r[k+1] <= ge ? rem_r[k] - dsh : rem_r[k];
      q_r[k+1]   <= {q_r[k][CW-2:0], ge};
      dm_r[k+1]  <= dm_r[k];
      neg_r[k+1] <= neg_r[k];
      ovf_r[k+1] <= ovf_r[k];
      wz_r[k+1]  <= wz_r[k];
    end
  end

  // valid bits of every stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      for (int k = 0; k <= CW; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_a_r  <= vld_i;
      vld_r[0] <= vld_a_r;
      for (int k = 0; k < CW; k++) vld_r[k+1] <= vld_r[k];
    end
  end

  // sign and clip
  logic [CW-1:0] qf, lim, res_nxt, res_r;
  logic          over, sat_nxt, sat_r, wzo_r, vldo_r;

  assign qf   = q_r[CW];
  assign lim  = neg_r[CW] ? NEG_MAX : POS_MAX;
  assign over = ovf_r[CW] || (qf > lim);

  always_comb begin
    res_nxt = '0;
    sat_nxt = 1'b0;
    if (!wz_r[CW]) begin
      if (over) begin
        res_nxt = lim;
        sat_nxt = 1'b1;
      end else begin
        res_nxt = neg_r[CW] ? -qf : qf;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    sat_r <= sat_nxt;
    wzo_r <= wz_r[CW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldo_r <= 1'b0;
    end else begin
      vldo_r <= vld_r[CW];
    end
  end

  assign ctrl_o = '{vld: vldo_r, wz: wzo_r};
  assign res_o  = res_r;
  assign sat_o  = sat_r;

  a_ovf_no_wz: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] && wz_r[0] |-> !ovf_r[0])
    else $error("overflow flagged on zero divisor");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[CW] && ovf_r[CW] |=> vldo_r && sat_r)
    else $error("overflow lost before output");

  a_wz_clean: assert property (@(posedge clk) disable iff (!rst_n)
    vldo_r && wzo_r |-> !sat_r && (res_r == '0))
    else $error("zero divisor result not cleared");

endmodule

// ===== rtl/core/homogeneous_point_transform.sv =====
// ----------------------------------------------------------------------------
// homogeneous_point_transform: 4x4 matrix point transform with divide by w
// Points pass the multiply and adder-tree stages, then the divide lanes with
// their one-bit-a-stage quotient pipeline; one point accepted every cycle,
// busy stays low. Results are strobed once and cannot be held off.
// Synchronous reset clears all valid bits and loads the identity matrix.
// ----------------------------------------------------------------------------
module homogeneous_point_transform #(
  parameter int COORD_WIDTH = hpt_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = hpt_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  hpt_pkg::in_item_t          in_data,
  output logic                       out_valid,
  output hpt_pkg::out_item_t         out_data,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [hpt_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [hpt_pkg::REG_W-1:0]  cfg_pwdata,
  output logic [hpt_pkg::REG_W-1:0]  cfg_prdata,
  output logic                       cfg_pready
);

  localparam int SW = hpt_pkg::sum_w(COORD_WIDTH, FRAC_BITS);

  logic [hpt_pkg::REG_W-1:0] regs [hpt_pkg::NUM_REGS];
  logic                      sum_vld;
  logic signed [SW-1:0]      sums [4];
  hpt_pkg::lane_ctrl_t       ctrl [3];
  logic [COORD_WIDTH-1:0]    res  [3];
  logic                      sat  [3];

  assign busy = 1'b0;

  hpt_cfg u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .regs_o(regs)
  );

  hpt_mac #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mac (
    .clk, .rst_n, .vld_i(start && !busy), .pt_i(in_data), .regs_i(regs),
    .vld_o(sum_vld), .sum_o(sums)
  );

  for (genvar l = 0; l < 3; l++) begin : g_lane
    hpt_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
      .clk, .rst_n, .vld_i(sum_vld), .num_i(sums[l]), .den_i(sums[3]),
      .ctrl_o(ctrl[l]), .res_o(res[l]), .sat_o(sat[l])
    );
  end

  // gather the lanes into one result transfer
  assign out_valid          = ctrl[0].vld;
  assign out_data.out_x     = 32'(signed'(res[0]));
  assign out_data.out_y     = 32'(signed'(res[1]));
  assign out_data.out_z     = 32'(signed'(res[2]));
  assign out_data.w_zero    = ctrl[0].wz;
  assign out_data.saturated = sat[0] | sat[1] | sat[2];

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl[0].vld == ctrl[1].vld) && (ctrl[0].vld == ctrl[2].vld)
    && (!ctrl[0].vld || ((ctrl[0].wz == ctrl[1].wz) && (ctrl[0].wz == ctrl[2].wz))))
    else $error("divider lanes out of step");

  a_wz_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.w_zero |-> !out_data.saturated && (out_data.out_x == 0)
    && (out_data.out_y == 0) && (out_data.out_z == 0))
    else $error("zero w result not cleared");

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !busy)
    else $error("pipeline refused a point");

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: bench for homogeneous_point_transform
// Loads matrices over the register port, then drives points. The directed
// table goes first, then random points under several matrices and idle rates.
// Every result strobe is checked, field by field, against the table's typed
// expectation or a fixed-point transform computed in the bench.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hpt_pkg::*;

  localparam int FRAC       = 16;
  localparam int RAND_ITEMS = 250;
  localparam int WDOG_LIMIT = 4000;
  localparam int DRAIN_WAIT = 60;

  // register indexes, in the order of the register map
  typedef enum int {
    R0_C01, R0_C23, R1_C01, R1_C23, R2_C01, R2_C23, R3_C01, R3_C23
  } reg_idx_e;

  typedef struct {
    logic [63:0] w_c23;
    in_item_t    pt;
    out_item_t   want;
    bit          typed;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  in_item_t            in_data;
  logic                out_valid;
  out_item_t           out_data;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [ADDR_W-1:0]   cfg_paddr;
  logic [REG_W-1:0]    cfg_pwdata;
  logic [REG_W-1:0]    cfg_prdata;
  logic                cfg_pready;

  logic [63:0] mat_q [NUM_REGS];
  out_item_t   pending_q [$];
  int          err_cnt;
  int          pt_cnt;
  int          res_cnt;
  int          wz_cnt;
  int          sat_cnt;
  int          idle_cnt;

  homogeneous_point_transform dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // coefficient of the bench's own matrix copy
  function automatic logic signed [31:0] coef(int row, int col);
    logic [63:0] rg;
    rg = mat_q[row * 2 + col / 2];
    return (col % 2) ? rg[63:32] : rg[31:0];
  endfunction

  // exact row sums, divide by w truncated toward zero, clip to 32 bits
  function automatic out_item_t transform(in_item_t p);
    logic signed [127:0] px, py, pz, c0, c1, c2, c3, num;
    logic signed [127:0] rsum [4];
    logic [127:0] nm, dm, q;
    logic [31:0]  lim;
    logic [31:0]  o [3];
    bit           nn, dn, sat;
    out_item_t    r;
    px = p.in_x;
    py = p.in_y;
    pz = p.in_z;
    for (int k = 0; k < 4; k++) begin
      c0 = coef(k, 0);
      c1 = coef(k, 1);
      c2 = coef(k, 2);
      c3 = coef(k, 3);
      c3 = c3 <<< FRAC;
      rsum[k] = c0 * px + c1 * py + c2 * pz + c3;
    end
    r = '0;
    if (rsum[3] == 0) begin
      r.w_zero = 1'b1;
      return r;
    end
    sat = 1'b0;
    dn  = rsum[3][127];
    dm  = dn ? -rsum[3] : rsum[3];
    for (int k = 0; k < 3; k++) begin
      num = rsum[k] <<< FRAC;
      nn  = num[127];
      nm  = nn ? -num : num;
      q   = nm / dm;
      lim = (nn == dn) ? 32'h7FFF_FFFF : 32'h8000_0000;
      if (q > {96'd0, lim}) begin
        sat = 1'b1;
        q   = {96'd0, lim};
      end
      o[k] = (nn != dn) ? -q[31:0] : q[31:0];
    end
    r.out_x     = o[0];
    r.out_y     = o[1];
    r.out_z     = o[2];
    r.saturated = sat;
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 8 << FRAC)) - (4 << FRAC));
      3: return 32'($signed($urandom_range(0, 64)) - 32) << FRAC;
      default: return 32'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  function automatic logic [31:0] small_coef();
    return 32'($signed($urandom_range(0, 4 << FRAC)) - (2 << FRAC));
  endfunction

  // wait for quiet, then a setup phase and an access phase
  task automatic write_reg(reg_idx_e idx, logic [63:0] val);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'(int'(idx) * 8);
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    mat_q[idx]  <= val;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // hold the point until taken, queue its expectation, then idle at random
  task automatic send_point(in_item_t p, out_item_t want, bit typed, int idle_pct);
    start   <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(typed ? want : transform(p));
    pt_cnt++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
    end
  endtask

  function automatic out_item_t mk_out(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                       logic wz, logic st);
    out_item_t r;
    r.out_x     = x;
    r.out_y     = y;
    r.out_z     = z;
    r.w_zero    = wz;
    r.saturated = st;
    return r;
  endfunction

  // check each strobed result against the oldest expectation
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid) begin
      res_cnt++;
      if (out_data.w_zero) wz_cnt++;
      if (out_data.saturated) sat_cnt++;
      if (pending_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result exp none got %h", $time, out_data);
      end else begin
        e = pending_q.pop_front();
        if (out_data.out_x !== e.out_x)
          $display("%0t: out_x exp %h got %h", $time, e.out_x, out_data.out_x);
        if (out_data.out_y !== e.out_y)
          $display("%0t: out_y exp %h got %h", $time, e.out_y, out_data.out_y);
        if (out_data.out_z !== e.out_z)
          $display("%0t: out_z exp %h got %h", $time, e.out_z, out_data.out_z);
        if (out_data.w_zero !== e.w_zero)
          $display("%0t: w_zero exp %b got %b", $time, e.w_zero, out_data.w_zero);
        if (out_data.saturated !== e.saturated)
          $display("%0t: saturated exp %b got %b", $time, e.saturated,
                   out_data.saturated);
        if (out_data !== e) err_cnt++;
      end
    end
  end

  // end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WDOG_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_q.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    dir_row_t    dir_tab [$];
    logic [63:0] cur_w;
    int          pct_tab [3];
    in_item_t    p;
    logic [63:0] v;
    err_cnt  = 0;
    pt_cnt   = 0;
    res_cnt  = 0;
    wz_cnt   = 0;
    sat_cnt  = 0;
    idle_cnt = 0;
    pct_tab  = '{0, 73, 18};
    for (int i = 0; i < NUM_REGS; i++) mat_q[i] = REG_RESET[i];
    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;

    // identity after reset: points pass straight through
    dir_tab.push_back('{64'h0001_0000_0000_0000, '{32'h0, 32'h0, 32'h0},
                       mk_out(32'h0, 32'h0, 32'h0, 1'b0, 1'b0), 1'b1});
    dir_tab.push_back('{64'h0001_0000_0000_0000,
                       '{32'h7FFF_FFFF, 32'h8000_0000, 32'h1},
                       mk_out(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 1'b0, 1'b0), 1'b1});
    dir_tab.push_back('{64'h0001_0000_0000_0000,
                       '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF},
                       mk_out(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0),
                       1'b1});
    dir_tab.push_back('{64'h0001_0000_0000_0000,
                       '{32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678},
                       mk_out(32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 1'b0, 1'b0),
                       1'b1});
    // w row all zero: flag raised, outputs cleared
    dir_tab.push_back('{64'h0, '{32'h7FFF_FFFF, 32'h8000_0000, 32'h1},
                       mk_out(32'h0, 32'h0, 32'h0, 1'b1, 1'b0), 1'b1});
    dir_tab.push_back('{64'h0, '{32'h0, 32'h0, 32'h0},
                       mk_out(32'h0, 32'h0, 32'h0, 1'b1, 1'b0), 1'b1});
    // w = 0.5: doubling clips at both ends
    dir_tab.push_back('{64'h0000_8000_0000_0000,
                       '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000},
                       mk_out(32'h7FFF_FFFF, 32'h8000_0000, 32'h0002_0000, 1'b0, 1'b1),
                       1'b1});
    dir_tab.push_back('{64'h0000_8000_0000_0000,
                       '{32'h3FFF_FFFF, 32'hC000_0000, 32'h0},
                       mk_out(32'h7FFF_FFFE, 32'h8000_0000, 32'h0, 1'b0, 1'b0), 1'b1});
    // w = -1: negating the most negative value clips
    dir_tab.push_back('{64'hFFFF_0000_0000_0000,
                       '{32'h8000_0000, 32'h7FFF_FFFF, 32'h5},
                       mk_out(32'h7FFF_FFFF, 32'h8000_0001, 32'hFFFF_FFFB, 1'b0, 1'b1),
                       1'b1});
    // w = 3: inexact quotients truncate toward zero
    dir_tab.push_back('{64'h0003_0000_0000_0000, '{32'h1, 32'hFFFF_FFFE, 32'h0001_0000},
                       '0, 1'b0});
    dir_tab.push_back('{64'h0003_0000_0000_0000,
                       '{32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000}, '0, 1'b0});
    // w = z: zero w from a point, then a perspective divide
    dir_tab.push_back('{64'h0000_0000_0001_0000, '{32'h0005_0000, 32'h7, 32'h0},
                       mk_out(32'h0, 32'h0, 32'h0, 1'b1, 1'b0), 1'b1});
    dir_tab.push_back('{64'h0000_0000_0001_0000,
                       '{32'h0005_0000, 32'hFFFD_0000, 32'h0000_0001}, '0, 1'b0});
    dir_tab.push_back('{64'h0000_0000_0001_0000,
                       '{32'h0005_0000, 32'h0003_0000, 32'hFFFE_0000}, '0, 1'b0});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table, reloading the w row's z and offset coefficients when they change
    cur_w = REG_RESET[R3_C23];
    foreach (dir_tab[i]) begin
      if (dir_tab[i].w_c23 != cur_w) begin
        write_reg(R3_C23, dir_tab[i].w_c23);
        cur_w = dir_tab[i].w_c23;
      end
      send_point(dir_tab[i].pt, dir_tab[i].want, dir_tab[i].typed, 30);
    end

    // random phases, each under its own matrix, with idle rates taken in turn from the table
    for (int ph = 0; ph < 6; ph++) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        case (ph)
          1:       v = {$urandom, $urandom};
          2:       v = (r % 2) ? 64'h7FFF_FFFF_8000_0000 : 64'h8000_0000_7FFF_FFFF;
          default: v = {small_coef(), small_coef()};
        endcase
        if (ph == 3 && r == R3_C01) v = 64'h0;
        if (ph == 3 && r == R3_C23) v = 64'h0001_0000_0000_0000;
        if (ph == 4 && r == R3_C01) v = 64'h0;
        if (ph == 4 && r == R3_C23) v = 64'h0000_0000_0001_0000;
        write_reg(reg_idx_e'(r), v);
      end
      for (int n = 0; n < RAND_ITEMS; n++) begin
        p.in_x = rand_coord();
        p.in_y = rand_coord();
        p.in_z = ($urandom_range(0, 15) == 0) ? 32'h0 : rand_coord();
        send_point(p, '0, 1'b0, pct_tab[ph % 3]);
      end
    end

    // drain
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d points under %0d matrix settings; %0d results checked,",
             pt_cnt, 7, res_cnt);
    $display("%0d with w zero and %0d clipped.", wz_cnt, sat_cnt);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
